FILE: rtl/core/sha256_message_digest_defines.svh
// Assertion macros shared by the SHA-256 digest checker.
// Expects signals named clk and rst in the scope that uses them.
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sha256md_pkg.sv
// Shared types and constants for the SHA-256 message digest block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package sha256md_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  bcount_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_LEN_LO,
    S_OUT
  } state_t;

  localparam bcount_t    FULL_WORD_BYTES = 3'd4;
  localparam logic [3:0] LAST_SLOT       = 4'd15;
  localparam logic [3:0] LEN_HI_SLOT     = 4'd14;
  localparam logic [5:0] LAST_ROUND      = 6'd63;
  localparam logic [2:0] LAST_DIGEST     = 3'd7;
  localparam word_t      PAD_WORD        = 32'h8000_0000;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

FILE: rtl/core/sha256md_if.sv
// Valid/ready channel interfaces for message words and digest words.
// Depends on sha256md_pkg for the payload types.
`default_nettype none

interface sha256md_msg_if;
  logic                 valid;
  logic                 ready;
  sha256md_pkg::word_t   data_word;
  sha256md_pkg::bcount_t byte_count;
  logic                 is_last;

  modport source (output valid, data_word, byte_count, is_last, input ready);
  modport sink   (input valid, data_word, byte_count, is_last, output ready);
endinterface

interface sha256md_digest_if;
  logic                valid;
  logic                ready;
  sha256md_pkg::word_t digest_word;
  logic                digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sha256_message_digest.sv
// SHA-256 digest engine: takes big-endian message words and returns the eight
// digest words after the last word. The message channel stays ready after a
// word that does not complete a block. The sixteenth word of a block starts the
// compression, which runs one round per cycle on a single shared round unit:
// 64 rounds, then a fold of the result into the chaining state. The message
// channel is not ready while a block is compressed. After the last word the
// block pushes the padding words (a marker word after a full last word, zeros
// and the two length words) and compresses each of the one or two closing
// blocks; then the digest channel offers words 0 through 7, and the block is
// ready for a new message after the transfer of word 7.
// Depends on sha256md_pkg and the channel interfaces in sha256md_if.sv.
`default_nettype none

module sha256_message_digest (
  input  logic                  clk,
  input  logic                  rst,
  sha256md_msg_if.sink          msg,
  sha256md_digest_if.source     digest
);

  // Rotate right by a constant amount.
  function automatic sha256md_pkg::word_t ror(input sha256md_pkg::word_t x,
                                              input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic sha256md_pkg::word_t big_sig0(input sha256md_pkg::word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic sha256md_pkg::word_t big_sig1(input sha256md_pkg::word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic sha256md_pkg::word_t small_sig0(input sha256md_pkg::word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic sha256md_pkg::word_t small_sig1(input sha256md_pkg::word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  sha256md_pkg::state_t state, state_next;
  sha256md_pkg::state_t ret, ret_next;

  sha256md_pkg::word_t chain [8];
  sha256md_pkg::word_t blk   [16];
  sha256md_pkg::word_t rr    [8];

  logic [3:0]            slot;
  logic [31:0]           msg_bytes;
  logic                  need80;
  logic [5:0]            round_idx;
  logic [2:0]            out_idx;

  logic                  msg_xfer;
  logic                  dig_xfer;
  logic                  push_en;
  logic                  block_full;
  sha256md_pkg::word_t   push_data;
  sha256md_pkg::state_t  after_push;
  sha256md_pkg::bcount_t cnt_norm;
  logic [32:0]           byte_sum;
  logic [31:0]           bytes_add;
  sha256md_pkg::word_t   short_word;
  sha256md_pkg::word_t   t1;
  sha256md_pkg::word_t   t2;
  sha256md_pkg::word_t   sched_word;

  // Handshake signals.
  assign msg.ready          = (state == sha256md_pkg::S_IDLE);
  assign digest.valid       = (state == sha256md_pkg::S_OUT);
  assign digest.digest_word = chain[out_idx];
  assign digest.digest_last = (out_idx == sha256md_pkg::LAST_DIGEST);
  assign msg_xfer           = msg.valid && msg.ready;
  assign dig_xfer           = digest.valid && digest.ready;

  // Byte count of the incoming word: counts above four mean a full word.
  assign cnt_norm = (msg.byte_count > sha256md_pkg::FULL_WORD_BYTES) ?
                    sha256md_pkg::FULL_WORD_BYTES : msg.byte_count;

  // Saturating byte counter update.
  always_comb begin
    bytes_add = (msg.is_last ? {29'd0, cnt_norm} : {29'd0, sha256md_pkg::FULL_WORD_BYTES});
    byte_sum  = {1'b0, msg_bytes} + {1'b0, bytes_add};
  end

  // A short last word keeps its leading bytes and carries the padding byte.
  always_comb begin
    case (cnt_norm)
      3'd1:    short_word = {msg.data_word[31:24], 24'h80_0000};
      3'd2:    short_word = {msg.data_word[31:16], 16'h8000};
      3'd3:    short_word = {msg.data_word[31:8], 8'h80};
      default: short_word = sha256md_pkg::PAD_WORD;
    endcase
  end

  // Sequencer: next state and the word pushed into the block buffer.
  always_comb begin
    push_en    = 1'b0;
    push_data  = '0;
    after_push = state;
    state_next = state;
    ret_next   = ret;
    unique case (state)
      sha256md_pkg::S_IDLE: begin
        if (msg_xfer) begin
          push_en = 1'b1;
          if (!msg.is_last || cnt_norm == sha256md_pkg::FULL_WORD_BYTES) begin
            push_data = msg.data_word;
          end else begin
            push_data = short_word;
          end
          after_push = msg.is_last ? sha256md_pkg::S_PAD : sha256md_pkg::S_IDLE;
        end
      end
      sha256md_pkg::S_PAD: begin
        push_en = 1'b1;
        if (need80) begin
          push_data  = sha256md_pkg::PAD_WORD;
          after_push = sha256md_pkg::S_PAD;
        end else if (slot != sha256md_pkg::LEN_HI_SLOT) begin
          push_data  = '0;
          after_push = sha256md_pkg::S_PAD;
        end else begin
          push_data  = {29'd0, msg_bytes[31:29]};
          after_push = sha256md_pkg::S_LEN_LO;
        end
      end
      sha256md_pkg::S_LEN_LO: begin
        push_en    = 1'b1;
        push_data  = {msg_bytes[28:0], 3'b000};
        after_push = sha256md_pkg::S_OUT;
      end
      sha256md_pkg::S_ROUND: begin
        if (round_idx == sha256md_pkg::LAST_ROUND) begin
          state_next = sha256md_pkg::S_FOLD;
        end
      end
      sha256md_pkg::S_FOLD: begin
        state_next = ret;
      end
      sha256md_pkg::S_OUT: begin
        if (dig_xfer && out_idx == sha256md_pkg::LAST_DIGEST) begin
          state_next = sha256md_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sha256md_pkg::S_IDLE;
      end
    endcase

    // A push into the last slot completes a block and starts compression.
    block_full = push_en && (slot == sha256md_pkg::LAST_SLOT);
    if (push_en) begin
      if (block_full) begin
        state_next = sha256md_pkg::S_ROUND;
        ret_next   = after_push;
      end else begin
        state_next = after_push;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256md_pkg::S_IDLE;
      ret   <= sha256md_pkg::S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Round unit and message schedule.
  always_comb begin
    t1 = rr[7] + big_sig1(rr[4]) + ((rr[4] & rr[5]) ^ (~rr[4] & rr[6]))
       + sha256md_pkg::ROUND_K[round_idx] + blk[0];
    t2 = big_sig0(rr[0]) + ((rr[0] & rr[1]) ^ (rr[0] & rr[2]) ^ (rr[1] & rr[2]));
    sched_word = small_sig1(blk[14]) + blk[9] + small_sig0(blk[1]) + blk[0];
  end

  // Control and chaining state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      msg_bytes <= '0;
      need80    <= 1'b0;
      round_idx <= '0;
      out_idx   <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha256md_pkg::INIT_HASH[i];
      end
    end else begin
      if (push_en) begin
        slot <= slot + 4'd1;
      end
      if (block_full) begin
        round_idx <= '0;
      end else if (state == sha256md_pkg::S_ROUND) begin
        round_idx <= round_idx + 6'd1;
      end
      if (msg_xfer) begin
        msg_bytes <= byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
        need80    <= msg.is_last && (cnt_norm == sha256md_pkg::FULL_WORD_BYTES);
      end else if (state == sha256md_pkg::S_PAD) begin
        need80 <= 1'b0;
      end
      if (state == sha256md_pkg::S_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + rr[i];
        end
      end
      // After the final digest transfer, return to the start of a message.
      if (dig_xfer) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == sha256md_pkg::LAST_DIGEST) begin
          msg_bytes <= '0;
          for (int i = 0; i < 8; i++) begin
            chain[i] <= sha256md_pkg::INIT_HASH[i];
          end
        end
      end
    end
  end

  // Block buffer as a shift line, and the working registers a..h.
  always_ff @(posedge clk) begin
    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        blk[i] <= blk[i+1];
      end
      blk[15] <= push_data;
    end else if (state == sha256md_pkg::S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        blk[i] <= blk[i+1];
      end
      blk[15] <= sched_word;
    end

    if (block_full) begin
      for (int i = 0; i < 8; i++) begin
        rr[i] <= chain[i];
      end
    end else if (state == sha256md_pkg::S_ROUND) begin
      rr[7] <= rr[6];
      rr[6] <= rr[5];
      rr[5] <= rr[4];
      rr[4] <= rr[3] + t1;
      rr[3] <= rr[2];
      rr[2] <= rr[1];
      rr[1] <= rr[0];
      rr[0] <= t1 + t2;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sha256md_checker.sv
// Port-level checker for the SHA-256 digest block, bound to its top level.
// Depends on sha256_message_digest_defines.svh for the assertion macros.
`default_nettype none

`include "sha256_message_digest_defines.svh"

module sha256md_checker (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_ready,
  input logic        msg_is_last,
  input logic        dig_valid,
  input logic        dig_ready,
  input logic [31:0] dig_word,
  input logic        dig_last
);

  logic msg_xfer;
  logic dig_xfer;

  assign msg_xfer = msg_valid && msg_ready;
  assign dig_xfer = dig_valid && dig_ready;

  // No message word is taken while digest words are offered.
  `SHA_ASSERT_NOW(a_no_msg_during_digest, dig_valid, !msg_ready, "message ready during digest")

  // The closing blocks must be compressed before any digest word shows.
  `SHA_ASSERT_NEXT(a_digest_not_immediate, msg_xfer && msg_is_last, !dig_valid,
                   "digest offered right after last word")

  // Digest words continue back to back until the final one.
  `SHA_ASSERT_NEXT(a_digest_continues, dig_xfer && !dig_last, dig_valid,
                   "digest stream broke before the last word")

  // The block is ready for a new message right after the final digest transfer.
  `SHA_ASSERT_NEXT(a_ready_after_digest, dig_xfer && dig_last, msg_ready,
                   "not ready after final digest word")

  // A stalled digest word holds its value.
  `SHA_ASSERT_NEXT(a_digest_hold, dig_valid && !dig_ready,
                   dig_valid && $stable(dig_word) && $stable(dig_last),
                   "stalled digest word changed")

endmodule

bind sha256_message_digest sha256md_checker u_sha256md_checker (
  .clk         (clk),
  .rst         (rst),
  .msg_valid   (msg.valid),
  .msg_ready   (msg.ready),
  .msg_is_last (msg.is_last),
  .dig_valid   (digest.valid),
  .dig_ready   (digest.ready),
  .dig_word    (digest.digest_word),
  .dig_last    (digest.digest_last)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the SHA-256 message digest block.
// Depends on sha256md_pkg, the channel interfaces in sha256md_if.sv and the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int GAP_MAX        = 14;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_WORDS   = 75;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam sha256md_pkg::word_t PAD_BYTE = 32'h0000_0080;

  typedef struct {
    sha256md_pkg::word_t word;
    logic                last;
  } digest_entry_t;

  logic clk = 1'b0;
  logic rst;

  sha256md_msg_if    msg_ch ();
  sha256md_digest_if digest_ch ();

  sha256_message_digest dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (digest_ch)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted hash state, kept in step with the words that the block accepts.
  sha256md_pkg::word_t hash_state [8];
  sha256md_pkg::word_t block_buf [16];
  logic [3:0]          fill_slot;
  logic [31:0]         byte_total;
  digest_entry_t       expected_digest [$];

  int  fail_count      = 0;
  int  words_sent      = 0;
  int  messages_sent   = 0;
  int  digests_checked = 0;
  int  quiet_cycles    = 0;
  logic send_steady    = 1'b0;
  logic recv_steady    = 1'b0;

  function automatic sha256md_pkg::word_t rotr(sha256md_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void clear_hash_state();
    hash_state = sha256md_pkg::INIT_HASH;
    fill_slot  = '0;
    byte_total = '0;
  endfunction

  // One 64-round compression of the block buffer into the hash state.
  function automatic void compress_block();
    sha256md_pkg::word_t sched [64];
    sha256md_pkg::word_t r [8];
    sha256md_pkg::word_t s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) sched[i] = block_buf[i];
    for (i = 16; i < 64; i++) begin
      s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
    end
    r = hash_state;
    for (i = 0; i < 64; i++) begin
      t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha256md_pkg::ROUND_K[i] + sched[i];
      t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6];
      r[6] = r[5];
      r[5] = r[4];
      r[4] = r[3] + t1;
      r[3] = r[2];
      r[2] = r[1];
      r[1] = r[0];
      r[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) hash_state[i] = hash_state[i] + r[i];
  endfunction

  function automatic void absorb_word(sha256md_pkg::word_t w);
    block_buf[fill_slot] = w;
    fill_slot = fill_slot + 1'b1;
    if (fill_slot == '0) compress_block();
  endfunction

  // The byte count sticks at its maximum instead of wrapping.
  function automatic void add_bytes(sha256md_pkg::bcount_t n);
    logic [32:0] sum;
    sum = {1'b0, byte_total} + {30'd0, n};
    byte_total = sum[32] ? '1 : sum[31:0];
  endfunction

  // Updates the prediction for one accepted word; a last word pads the message
  // and queues the eight digest words.
  function automatic void predict_word(sha256md_pkg::word_t data,
                                       sha256md_pkg::bcount_t cnt, logic last);
    sha256md_pkg::bcount_t n;
    sha256md_pkg::word_t   keep;
    logic [63:0]           bit_len;
    int                    k;
    n = (cnt > sha256md_pkg::FULL_WORD_BYTES || !last) ?
        sha256md_pkg::FULL_WORD_BYTES : cnt;
    if (!last) begin
      absorb_word(data);
      add_bytes(sha256md_pkg::FULL_WORD_BYTES);
      return;
    end
    add_bytes(n);
    if (n == sha256md_pkg::FULL_WORD_BYTES) begin
      absorb_word(data);
      absorb_word(sha256md_pkg::PAD_WORD);
    end else begin
      keep = (n == '0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * n));
      absorb_word((data & keep) | (PAD_BYTE << (24 - 8 * n)));
    end
    if (fill_slot == sha256md_pkg::LAST_SLOT) absorb_word('0);
    while (fill_slot != sha256md_pkg::LEN_HI_SLOT) absorb_word('0);
    bit_len = {32'b0, byte_total} << 3;
    absorb_word(bit_len[63:32]);
    absorb_word(bit_len[31:0]);
    for (k = 0; k < 8; k++) begin
      expected_digest.push_back('{word: hash_state[k],
                                  last: (k == sha256md_pkg::LAST_DIGEST)});
    end
    clear_hash_state();
  endfunction

  // Offers one message word after a random gap, or at once when sending steadily,
  // and waits for its transfer. Valid stays high on return so that back-to-back words need no low cycle.
  task automatic send_word(input sha256md_pkg::word_t data,
                           input sha256md_pkg::bcount_t cnt, input logic last);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid      <= 1'b1;
    msg_ch.data_word  <= data;
    msg_ch.byte_count <= cnt;
    msg_ch.is_last    <= last;
    do @(posedge clk); while (!msg_ch.ready);
    predict_word(data, cnt, last);
    words_sent++;
    if (last) messages_sent++;
  endtask

  // Digest sink: random stalls per word unless receiving steadily, then the check
  // against the oldest predicted word.
  initial begin : digest_sink
    int            stall;
    digest_entry_t want;
    digest_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = recv_steady ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        digest_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digest_ch.ready <= 1'b1;
      do @(posedge clk); while (!digest_ch.valid);
      digests_checked++;
      if (expected_digest.size() == 0) begin
        $error("unexpected digest transfer: digest_word %h digest_last %b",
               digest_ch.digest_word, digest_ch.digest_last);
        fail_count++;
      end else begin
        want = expected_digest.pop_front();
        if (digest_ch.digest_word !== want.word) begin
          $error("digest_word mismatch: expected %h, actual %h",
                 want.word, digest_ch.digest_word);
          fail_count++;
        end
        if (digest_ch.digest_last !== want.last) begin
          $error("digest_last mismatch: expected %b, actual %b",
                 want.last, digest_ch.digest_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (digest_ch.valid && digest_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Empty message, the classic three-byte message and a single zero byte.
  task automatic test_short_messages();
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'h0000_0000, 3'd1, 1'b1);
  endtask

  // Bytes past the count are nonzero and must not reach the hash.
  task automatic test_byte_masking();
    send_word(32'hA5FF_FFFF, 3'd1, 1'b1);
    send_word(32'h1234_5678, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
  endtask

  // Counts of five to seven on a last word behave as a full word.
  task automatic test_count_above_four();
    send_word(32'hDEAD_BEEF, 3'd5, 1'b1);
    send_word(32'h0F1E_2D3C, 3'd6, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
  endtask

  // Short counts on words that are not last are ignored.
  task automatic test_ignored_short_count();
    send_word(32'h0102_0304, 3'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b0);
    send_word(32'h0A0B_0C0D, 3'd2, 1'b1);
  endtask

  // Fourteen full words leave no room for the length, so padding spills into
  // a second block. The words arrive back to back.
  task automatic test_two_block_padding();
    int i;
    send_steady = 1'b1;
    for (i = 0; i < 14; i++) begin
      send_word($urandom, sha256md_pkg::FULL_WORD_BYTES, i == 13);
    end
    send_steady = 1'b0;
  endtask

  // Random messages, with lengths clustered around the block boundaries.
  task automatic test_random_messages(input int target_words);
    int                    len;
    int                    start;
    int                    i;
    sha256md_pkg::bcount_t cnt;
    start = words_sent;
    while (words_sent - start < target_words) begin
      case ($urandom_range(0, 3))
        0:       len = $urandom_range(1, 4);
        1:       len = $urandom_range(13, 17);
        2:       len = $urandom_range(28, 33);
        default: len = $urandom_range(1, 40);
      endcase
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      for (i = 1; i <= len; i++) begin
        if (i == len || $urandom_range(0, 3) == 0) begin
          cnt = sha256md_pkg::bcount_t'($urandom_range(0, 7));
        end else begin
          cnt = sha256md_pkg::FULL_WORD_BYTES;
        end
        send_word($urandom, cnt, i == len);
      end
    end
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  // Test sequence.
  initial begin
    rst               = 1'b1;
    msg_ch.valid      = 1'b0;
    msg_ch.data_word  = '0;
    msg_ch.byte_count = '0;
    msg_ch.is_last    = 1'b0;
    clear_hash_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_messages();
    test_byte_masking();
    test_count_above_four();
    test_ignored_short_count();
    test_two_block_padding();
    test_random_messages(RANDOM_WORDS);

    msg_ch.valid <= 1'b0;
    while (expected_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d words; %0d digest words compared.",
             messages_sent, words_sent, digests_checked);
    $display("Mix: short, masked, oversized-count and multi-block messages, random stalls.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
